// File: rtl/owf_pkg.sv
// Shared field widths, codes and output layout of the overlap window framer.
package owf_pkg;

    localparam int COEF_INDEX_W = 6;
    localparam int CFG_W        = 7;
    localparam int PRODUCT_W    = 32;
    localparam int FRAME_W      = 16;
    localparam int POS_W        = 6;

    // Output tdata: product, then frame index, then position, padded to bytes.
    localparam int OUT_FIELDS_W = PRODUCT_W + FRAME_W + POS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FRAME_LO = PRODUCT_W;
    localparam int OUT_POS_LO   = PRODUCT_W + FRAME_W;

    // Input tuser bit layout.
    localparam int USER_ACTION_BIT = 0;
    localparam int USER_NEW_BIT    = 1;
    localparam int IN_TUSER_W      = 2;

    // Item kinds carried in the action bit.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

endpackage

// File: rtl/overlap_window_framer_top.sv
// Top level of the overlap window framer: ring and window memories, frame sequencer, multiplier.
//
// The block cuts a stream of samples into frames of L samples that overlap by half
// (hop = floor(L/2)) and multiplies each frame by a window held in memory.
// Input channel s_axis: tuser bit 0 selects a window load (0) or a sample (1);
// tuser bit 1 marks the first sample of a new signal, which restarts the counts.
// A load writes one window coefficient, and a sample is written into the ring
// memory. When a sample completes a frame, the sequencer reads one word of the
// ring and one of the window per cycle while the receiver does not stall, and the
// input stays not ready until the whole frame has been read out.
// Each of the two memories has a single read port.
// Output channel m_axis: one transfer per frame position, tlast on the last one.
// After the transfer of the sample that completes a frame, the sequencer enters readout;
// each product then passes the memory read, the multiply and the output register.
// When the receiver stalls, the whole read/multiply pipeline holds, including
// the memory read registers; the input can still take items while a finished
// result waits, as long as no frame is being read out.
// Reset (synchronous, active low) sets L to MAX_WINDOW_LEN and clears the counts
// and the output valid. Memory contents are not cleared; window entries must be
// loaded before use. Writing the length register also restarts the signal.
module overlap_window_framer_top
    import owf_pkg::*;
#(
    parameter int MAX_WINDOW_LEN = 64,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Length register write.
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    // Input items.
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata from bit 0: coef_index, coef_value, sample, zero padding.
    input  logic [((COEF_INDEX_W + 2*SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser from bit 0: action, new_signal.
    input  logic [IN_TUSER_W-1:0]   s_axis_tuser,
    // Result items.
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata from bit 0: product, frame_index, position, zero padding.
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                    m_axis_tlast
);

    localparam int AW = $clog2(MAX_WINDOW_LEN);
    localparam int LW = $clog2(MAX_WINDOW_LEN + 1);
    localparam int PW = 2 * SAMPLE_BITS;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state_e;

    t_state_e r_state;

    // Input field extraction.
    logic [COEF_INDEX_W-1:0] w_coef_index;
    logic [SAMPLE_BITS-1:0]  w_coef_value;
    logic [SAMPLE_BITS-1:0]  w_sample;
    logic                    w_action;
    logic                    w_new_signal;

    assign w_coef_index = s_axis_tdata[COEF_INDEX_W-1:0];
    assign w_coef_value = s_axis_tdata[COEF_INDEX_W +: SAMPLE_BITS];
    assign w_sample     = s_axis_tdata[COEF_INDEX_W + SAMPLE_BITS +: SAMPLE_BITS];
    assign w_action     = s_axis_tuser[USER_ACTION_BIT];
    assign w_new_signal = s_axis_tuser[USER_NEW_BIT];

    // Control registers.
    logic [LW-1:0]      r_len;
    logic [LW-1:0]      r_until;
    logic [AW-1:0]      r_wp;
    logic [FRAME_W-1:0] r_frame;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW-1:0]      r_pos;
    logic [FRAME_W-1:0] r_emit_frame;

    // Pipeline: stage A is the memory read, stage B the product, then the output register.
    logic               r_a_v;
    logic [FRAME_W-1:0] r_a_frame;
    logic [AW-1:0]      r_a_pos;
    logic               r_a_last;
    logic               r_b_v;
    logic [PRODUCT_W-1:0] r_b_prod;
    logic [FRAME_W-1:0] r_b_frame;
    logic [AW-1:0]      r_b_pos;
    logic               r_b_last;
    logic               r_o_v;
    logic [PRODUCT_W-1:0] r_o_prod;
    logic [FRAME_W-1:0] r_o_frame;
    logic [AW-1:0]      r_o_pos;
    logic               r_o_last;

    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] v);
        logic [AW-1:0] res;
        if (v == AW'(MAX_WINDOW_LEN - 1)) begin
            res = '0;
        end else begin
            res = v + 1'b1;
        end
        return res;
    endfunction

    logic w_in_xfer;
    logic w_load;
    logic w_samp;
    logic w_advance;
    logic w_issue;
    logic w_issue_last;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_in_xfer && (w_action == ACT_LOAD) &&
                           (7'(w_coef_index) < 7'(MAX_WINDOW_LEN));
    assign w_samp        = w_in_xfer && (w_action == ACT_SAMPLE);
    assign w_advance     = !r_o_v || m_axis_tready;
    assign w_issue       = (r_state == ST_EMIT) && w_advance;
    assign w_issue_last  = (LW'(r_pos) == r_len - 1'b1);

    // Counts as seen by the current sample after an optional restart.
    logic [AW-1:0]      w_wp_eff;
    logic [LW-1:0]      w_until_eff;
    logic [FRAME_W-1:0] w_frame_eff;
    logic [AW-1:0]      n_wp;
    logic [LW-1:0]      w_next_ext;
    logic [LW-1:0]      w_start_ext;
    logic [LW-1:0]      n_len;

    always_comb begin
        w_wp_eff    = w_new_signal ? '0 : r_wp;
        w_until_eff = w_new_signal ? r_len : r_until;
        w_frame_eff = w_new_signal ? '0 : r_frame;
        n_wp        = inc_wrap(w_wp_eff);
        w_next_ext  = LW'(n_wp);
        // Oldest sample of the frame, modulo the ring depth.
        if (w_next_ext >= r_len) begin
            w_start_ext = w_next_ext - r_len;
        end else begin
            w_start_ext = w_next_ext + (LW'(MAX_WINDOW_LEN) - r_len);
        end
        // Length register clamped to the supported range.
        if (i_cfg_wdata < 7'd2) begin
            n_len = LW'(2);
        end else if (i_cfg_wdata > 7'(MAX_WINDOW_LEN)) begin
            n_len = LW'(MAX_WINDOW_LEN);
        end else begin
            n_len = LW'(i_cfg_wdata);
        end
    end

    // Memories.
    logic [SAMPLE_BITS-1:0] w_ring_q;
    logic [SAMPLE_BITS-1:0] w_win_q;

    owf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_samp),
        .i_waddr (w_wp_eff),
        .i_wdata (w_sample),
        .i_re    (w_issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_ring_q)
    );

    owf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_coef_index[AW-1:0]),
        .i_wdata (w_coef_value),
        .i_re    (w_issue),
        .i_raddr (r_pos),
        .o_rdata (w_win_q)
    );

    // Product of the two read words, reduced or sign-extended to the output width.
    logic signed [PW-1:0]  w_mul;
    logic [PRODUCT_W-1:0]  w_prod;

    assign w_mul = $signed(w_win_q) * $signed(w_ring_q);

    generate
        if (PW >= PRODUCT_W) begin : g_trunc
            assign w_prod = w_mul[PRODUCT_W-1:0];
        end else begin : g_ext
            assign w_prod = {{(PRODUCT_W - PW){w_mul[PW-1]}}, w_mul};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= LW'(MAX_WINDOW_LEN);
            r_until <= LW'(MAX_WINDOW_LEN);
            r_wp    <= '0;
            r_frame <= '0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len   <= n_len;
                r_until <= n_len;
                r_wp    <= '0;
                r_frame <= '0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_samp) begin
                        r_wp <= n_wp;
                        if (w_until_eff > LW'(1)) begin
                            r_until <= w_until_eff - 1'b1;
                            r_frame <= w_frame_eff;
                        end else begin
                            r_until      <= r_len >> 1;
                            r_frame      <= w_frame_eff + 1'b1;
                            r_emit_frame <= w_frame_eff;
                            r_rd_ptr     <= AW'(w_start_ext);
                            r_pos        <= '0;
                            r_state      <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_issue) begin
                        r_rd_ptr <= inc_wrap(r_rd_ptr);
                        r_pos    <= r_pos + 1'b1;
                        if (w_issue_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_advance) begin
                r_a_v     <= w_issue;
                r_a_frame <= r_emit_frame;
                r_a_pos   <= r_pos;
                r_a_last  <= w_issue_last;
                r_b_v     <= r_a_v;
                r_b_prod  <= w_prod;
                r_b_frame <= r_a_frame;
                r_b_pos   <= r_a_pos;
                r_b_last  <= r_a_last;
                r_o_v     <= r_b_v;
                r_o_prod  <= r_b_prod;
                r_o_frame <= r_b_frame;
                r_o_pos   <= r_b_pos;
                r_o_last  <= r_b_last;
            end
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = OUT_TDATA_W'({POS_W'(r_o_pos), r_o_frame, r_o_prod});

endmodule

// File: rtl/owf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module owf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/owf_checker.sv
// Port-level checks of the overlap window framer output stream, bound to the top level.
module owf_checker
    import owf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    logic               w_xfer;
    logic [POS_W-1:0]   w_pos;
    logic [FRAME_W-1:0] w_frame;

    assign w_xfer  = m_axis_tvalid && m_axis_tready;
    assign w_pos   = m_axis_tdata[OUT_POS_LO +: POS_W];
    assign w_frame = m_axis_tdata[OUT_FRAME_LO +: FRAME_W];

    // Position and frame of the previous output transfer.
    logic               r_seen;
    logic               r_prev_last;
    logic [POS_W-1:0]   r_prev_pos;
    logic [FRAME_W-1:0] r_prev_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_xfer) begin
            r_seen       <= 1'b1;
            r_prev_last  <= m_axis_tlast;
            r_prev_pos   <= w_pos;
            r_prev_frame <= w_frame;
        end
    end

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A stalled result stays offered and unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // Products of a frame come out in position order without gaps.
    a_pos_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && r_seen && !r_prev_last |->
            (w_pos == r_prev_pos + 1'b1) && (w_frame == r_prev_frame))
        else $error("frame position out of order");

    // A frame starts at position zero.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && (!r_seen || r_prev_last) |-> (w_pos == '0))
        else $error("frame does not start at position zero");

    // Frames have at least two positions, so the last one is never position zero.
    a_last_not_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (w_pos != '0))
        else $error("frame end at position zero");

endmodule

bind overlap_window_framer_top owf_checker u_owf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_overlap_window_framer_top.sv
// Self-checking testbench for the overlap window framer: windowed, half-overlapped frames.
`timescale 1ns / 1ps

module tb_overlap_window_framer_top;
    import owf_pkg::*;

    localparam int WIN_MAX    = 64;
    localparam int Q15_W      = 16;
    localparam int IN_TDATA_W = ((COEF_INDEX_W + 2 * Q15_W + 7) / 8) * 8;
    localparam int PAD_W      = IN_TDATA_W - COEF_INDEX_W - 2 * Q15_W;

    // One input item as the sender sees it, before packing onto the stream.
    typedef struct packed {
        logic                    action;
        logic [COEF_INDEX_W-1:0] idx;
        logic signed [Q15_W-1:0] coef;
        logic signed [Q15_W-1:0] smp;
        logic                    new_sig;
    } framer_item_t;

    // One windowed product as the block should deliver it.
    typedef struct packed {
        logic signed [PRODUCT_W-1:0] product;
        logic [FRAME_W-1:0]          frame;
        logic [POS_W-1:0]            pos;
        logic                        last;
    } windowed_sample_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    overlap_window_framer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Items waiting to be sent, and products still owed by the block.
    framer_item_t     send_q[$];
    windowed_sample_t products_due[$];
    framer_item_t     item_on_bus;
    int               queued_cnt = 0;
    int               taken_cnt = 0;
    int               mismatch_cnt = 0;
    // Set during one phase so that both sides run without any idle cycles.
    logic             no_gaps = 1'b0;

    // Shadow copy of the framer state: ring, window, counts and length.
    logic signed [Q15_W-1:0] ring_shadow [WIN_MAX];
    logic signed [Q15_W-1:0] window_shadow [WIN_MAX];
    logic [5:0]              wr_ptr;
    int                      samples_left;
    logic [FRAME_W-1:0]      frame_no;
    int                      frame_len;

    function automatic int clamp_length(input logic [CFG_W-1:0] v);
        if (v < 2) return 2;
        if (v > WIN_MAX) return WIN_MAX;
        return int'(v);
    endfunction

    function automatic void restart_signal();
        wr_ptr       = '0;
        frame_no     = '0;
        samples_left = frame_len;
    endfunction

    // Update the shadow state with one accepted item and queue the products
    // of the frame it completes, if it completes one.
    function automatic void predict_frame(input framer_item_t it);
        int                      first;
        logic signed [Q15_W-1:0] s;
        longint                  p;
        windowed_sample_t        r;
        if (it.action == ACT_LOAD) begin
            window_shadow[it.idx] = it.coef;
            return;
        end
        if (it.new_sig) restart_signal();
        ring_shadow[wr_ptr] = it.smp;
        wr_ptr = wr_ptr + 6'd1;
        if (samples_left > 1) begin
            samples_left--;
            return;
        end
        first = (int'(wr_ptr) + WIN_MAX - frame_len) % WIN_MAX;
        for (int j = 0; j < frame_len; j++) begin
            s         = ring_shadow[(first + j) % WIN_MAX];
            p         = longint'(window_shadow[j]) * longint'(s);
            r.product = p[PRODUCT_W-1:0];
            r.frame   = frame_no;
            r.pos     = POS_W'(j);
            r.last    = (j == frame_len - 1);
            products_due.push_back(r);
        end
        frame_no     = frame_no + 1'b1;
        samples_left = frame_len / 2;
    endfunction

    // Mostly ordinary Q1.15 values, with the corners showing up often.
    function automatic logic [Q15_W-1:0] pick_q15();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return Q15_W'($urandom);
        endcase
    endfunction

    function automatic framer_item_t load_item(input int idx, input logic [Q15_W-1:0] v,
                                               input logic new_flag);
        framer_item_t it;
        it.action  = ACT_LOAD;
        it.idx     = COEF_INDEX_W'(idx);
        it.coef    = v;
        it.smp     = Q15_W'($urandom);
        it.new_sig = new_flag;
        return it;
    endfunction

    function automatic framer_item_t sample_item(input logic [Q15_W-1:0] v,
                                                 input logic new_flag);
        framer_item_t it;
        it.action  = ACT_SAMPLE;
        it.idx     = COEF_INDEX_W'($urandom);
        it.coef    = Q15_W'($urandom);
        it.smp     = v;
        it.new_sig = new_flag;
        return it;
    endfunction

    task automatic queue_item(input framer_item_t it);
        send_q.push_back(it);
        queued_cnt++;
    endtask

    // Wait until every queued item has been taken and every product has come
    // out, then wait on so that the block can finish a sample that made no frame.
    task automatic drain();
        while (taken_cnt != queued_cnt || products_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write the length register while the block is idle; the write also
    // restarts the signal, so the shadow counts restart with it.
    task automatic write_length(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        frame_len = clamp_length(v);
        restart_signal();
    endtask

    // Sender: holds an item on the bus until its transfer, then either takes
    // the next one from the queue or, at random or when none is queued, idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_frame(item_on_bus);
                taken_cnt++;
            end
            if (send_q.size() != 0 && (no_gaps || $urandom_range(99) >= 11)) begin
                item_on_bus = send_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{PAD_W{1'b0}}, item_on_bus.smp, item_on_bus.coef,
                                  item_on_bus.idx};
                s_axis_tuser[USER_ACTION_BIT] <= item_on_bus.action;
                s_axis_tuser[USER_NEW_BIT]    <= item_on_bus.new_sig;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transfer against the oldest expected
    // product and stalls at random between transfers.
    always @(posedge i_clk) begin
        windowed_sample_t want;
        windowed_sample_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.product = m_axis_tdata[PRODUCT_W-1:0];
            got.frame   = m_axis_tdata[OUT_FRAME_LO +: FRAME_W];
            got.pos     = m_axis_tdata[OUT_POS_LO +: POS_W];
            got.last    = m_axis_tlast;
            if (products_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: product %0d frame %0d pos %0d last %0b",
                             got.product, got.frame, got.pos, got.last);
            end else begin
                want = products_due.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch: expected product %0d frame %0d pos %0d last %0b",
                                 want.product, want.frame, want.pos, want.last);
                        $display("          got product %0d frame %0d pos %0d last %0b",
                                 got.product, got.frame, got.pos, got.last);
                    end
                end
            end
        end
        m_axis_tready <= no_gaps || ($urandom_range(99) >= 11);
    end

    // Stimulus, in phases separated by length writes on an idle block.
    initial begin
        int lengths [4];
        lengths   = '{5, 1, 127, 0};
        frame_len = WIN_MAX;
        restart_signal();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset length: load the whole window, with full-scale corners at both
        // ends, then one frame of samples plus a tail sample that is dropped.
        // Neither side idles during this stretch.
        for (int j = 0; j < WIN_MAX; j++) begin
            if (j == 0 || j == WIN_MAX - 1)
                queue_item(load_item(j, 16'h8000, 1'b0));
            else if (j == 1 || j == WIN_MAX - 2)
                queue_item(load_item(j, 16'h7FFF, 1'b0));
            else
                queue_item(load_item(j, pick_q15(), j[0]));
        end
        no_gaps = 1'b1;
        for (int j = 0; j < WIN_MAX + 1; j++) begin
            if (j == 0 || j == WIN_MAX - 1)
                queue_item(sample_item(16'h8000, 1'b0));
            else
                queue_item(sample_item(pick_q15(), 1'b0));
        end
        drain();
        no_gaps = 1'b0;

        // Shortest frames: corner products, a load that carries a stray new
        // signal flag, restarts in mid-signal and back to back, and a load of
        // a position beyond the current length.
        write_length(7'd2);
        queue_item(load_item(0, 16'h8000, 1'b0));
        queue_item(load_item(1, 16'h7FFF, 1'b0));
        queue_item(sample_item(16'h8000, 1'b0));
        queue_item(sample_item(16'h8000, 1'b0));
        queue_item(sample_item(16'h7FFF, 1'b0));
        queue_item(sample_item(16'h0000, 1'b0));
        queue_item(load_item(1, 16'h0001, 1'b1));
        queue_item(sample_item(16'h3039, 1'b1));
        queue_item(sample_item(16'hFFFF, 1'b0));
        queue_item(load_item(63, 16'h7FFF, 1'b0));
        queue_item(sample_item(16'h7FFF, 1'b1));
        queue_item(sample_item(16'h8000, 1'b1));
        queue_item(sample_item(16'h8000, 1'b0));
        queue_item(load_item(0, 16'h7FFF, 1'b0));
        queue_item(sample_item(16'h7FFF, 1'b0));
        queue_item(sample_item(16'h8001, 1'b0));

        // Random phases: short sample streams with random content, with
        // some loads, rare restarts and stray flags mixed in, at lengths
        // inside and outside the supported range.
        foreach (lengths[k]) begin
            write_length(CFG_W'(lengths[k]));
            for (int n = 0; n < 6; n++) begin
                if ($urandom_range(99) < 10)
                    queue_item(load_item($urandom_range(WIN_MAX - 1), pick_q15(),
                                         1'($urandom)));
                else
                    queue_item(sample_item(pick_q15(), $urandom_range(99) < 3));
            end
            drain();
        end

        drain();
        repeat (12) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("tb_overlap_window_framer_top passed");
        else
            $display("tb_overlap_window_framer_top failed");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2000000;
        $display("tb_overlap_window_framer_top failed");
        $finish;
    end

endmodule
